[rtl/core/relr_pkg.sv]
// Package for the RELR relocation decoder: constants, controller state,
// the command/status structs between controller and datapath, and the
// lowest-set-bit encoder. No dependencies.
package relr_pkg;

  localparam int unsigned AddrW      = 64;
  localparam int unsigned WordBytes  = 8;
  localparam int unsigned BitmapBits = 64;
  localparam int unsigned BmpW       = BitmapBits - 1;
  localparam int unsigned IdxW       = $clog2(BmpW);
  localparam int unsigned ShiftW     = $clog2(WordBytes);
  localparam logic [AddrW-1:0] WordStep   = AddrW'(WordBytes);
  localparam logic [AddrW-1:0] BitmapStep = AddrW'(WordBytes * BmpW);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } relr_state_e;

  typedef struct packed {
    logic accept;  // take the input word and set up its decode
    logic emit;    // load the next address into the output register
  } relr_cmd_t;

  typedef struct packed {
    logic rem_zero;    // no address left for the current entry
    logic rem_single;  // at most one address left
    logic out_free;    // output register can take a word this cycle
  } relr_sts_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [IdxW-1:0] lowest_set(input logic [BmpW-1:0] v);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = BmpW - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

[rtl/core/relr_if.sv]
// Channel interfaces of the RELR relocation decoder: input words, output
// words and the load-bias write channel. Depends on relr_pkg.
interface relr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       table_start;
  logic [relr_pkg::AddrW-1:0] relr_entry;

  modport source (output valid, output table_start, output relr_entry, input ready);
  modport sink (input valid, input table_start, input relr_entry, output ready);
endinterface

interface relr_out_if;
  logic                       valid;
  logic                       ready;
  logic [relr_pkg::AddrW-1:0] patch_address;
  logic                       last;

  modport source (output valid, output patch_address, output last, input ready);
  modport sink (input valid, input patch_address, input last, output ready);
endinterface

interface relr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [relr_pkg::AddrW-1:0] bias;

  modport source (output valid, output bias, input ready);
  modport sink (input valid, input bias, output ready);
endinterface

[rtl/core/relr_ctrl.sv]
// Controller of the RELR relocation decoder: accepts an input word, then
// steps the datapath through its addresses. Depends on relr_pkg.
module relr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  relr_pkg::relr_sts_t sts_i,
  output relr_pkg::relr_cmd_t cmd_o
);

  relr_pkg::relr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= relr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      relr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = relr_pkg::ST_EMIT;
        end
      end
      relr_pkg::ST_EMIT: begin
        // Leave as the final address goes out, or at once for an empty entry.
        if (sts_i.rem_zero || (sts_i.rem_single && sts_i.out_free)) begin
          state_d = relr_pkg::ST_IDLE;
        end
      end
      default: state_d = relr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      relr_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      relr_pkg::ST_EMIT: begin
        cmd_o.emit = !sts_i.rem_zero && sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[rtl/core/relr_dp.sv]
// Datapath of the RELR relocation decoder: load bias, address cursor,
// pending bitmap, biased base and the output register. Depends on relr_pkg
// and the channel interfaces in relr_if.sv.
module relr_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       table_start_i,
  input  logic [relr_pkg::AddrW-1:0] relr_entry_i,
  relr_cfg_if.sink                   cfg_i,
  relr_out_if.source                 out_o,
  input  relr_pkg::relr_cmd_t        cmd_i,
  output relr_pkg::relr_sts_t        sts_o
);

  logic [relr_pkg::AddrW-1:0] bias_q, bias_d;
  logic [relr_pkg::AddrW-1:0] cursor_q, cursor_d;
  logic [relr_pkg::AddrW-1:0] base_q, base_d;
  logic [relr_pkg::BmpW-1:0]  rem_q, rem_d;
  logic                       out_valid_q, out_valid_d;
  logic [relr_pkg::AddrW-1:0] out_addr_q, out_addr_d;
  logic                       out_last_q, out_last_d;

  logic [relr_pkg::AddrW-1:0] cur_eff;
  logic [relr_pkg::AddrW-1:0] base_sel;
  logic                       is_addr;
  logic [relr_pkg::BmpW-1:0]  rem_rest;
  logic [relr_pkg::IdxW-1:0]  idx;

  assign cfg_i.ready = 1'b1;

  assign cur_eff  = table_start_i ? '0 : cursor_q;
  assign is_addr  = !relr_entry_i[0];
  assign base_sel = is_addr ? relr_entry_i : cur_eff;
  assign rem_rest = rem_q & (rem_q - relr_pkg::BmpW'(1));
  assign idx      = relr_pkg::lowest_set(rem_q);

  assign sts_o.rem_zero   = (rem_q == '0);
  assign sts_o.rem_single = (rem_rest == '0);
  assign sts_o.out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    bias_d      = bias_q;
    cursor_d    = cursor_q;
    base_d      = base_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_last_d  = out_last_q;

    if (cfg_i.valid) begin
      bias_d = cfg_i.bias;
    end

    if (cmd_i.accept) begin
      base_d = base_sel + bias_q;
      if (is_addr) begin
        cursor_d = relr_entry_i + relr_pkg::WordStep;
      end else begin
        cursor_d = cur_eff + relr_pkg::BitmapStep;
      end
      // An address word is a one-bit bitmap at offset zero; a zero bias
      // suppresses every word but the cursor still moves.
      if (bias_q == '0) begin
        rem_d = '0;
      end else if (is_addr) begin
        rem_d = relr_pkg::BmpW'(1);
      end else begin
        rem_d = relr_entry_i[relr_pkg::AddrW-1:1];
      end
    end

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_addr_d  = base_q + relr_pkg::AddrW'({idx, relr_pkg::ShiftW'(0)});
      out_last_d  = sts_o.rem_single;
      rem_d       = rem_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q      <= '0;
      cursor_q    <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bias_q      <= bias_d;
      cursor_q    <= cursor_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    out_addr_q <= out_addr_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.patch_address = out_addr_q;
  assign out_o.last          = out_last_q;

endmodule

[rtl/core/relr_relocation_decoder.sv]
// RELR relocation decoder: takes one 64-bit RELR table word at a time and
// returns the biased addresses of the words to relocate, one per cycle while
// the output is not stalled, with last marking the final address of each
// word. A new input word is taken only once every address of the last one
// has gone into the output register. A single base-plus-offset adder forms
// one address per cycle. A zero load bias yields no output, but the cursor
// still advances.
// Depends on relr_pkg, relr_if.sv, relr_ctrl and relr_dp.
module relr_relocation_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  relr_in_if.sink    in_i,
  relr_cfg_if.sink   cfg_i,
  relr_out_if.source out_o
);

  relr_pkg::relr_cmd_t cmd;
  relr_pkg::relr_sts_t sts;
  logic                in_ready;

  assign in_i.ready = in_ready;

  relr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  relr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .table_start_i (in_i.table_start),
    .relr_entry_i  (in_i.relr_entry),
    .cfg_i         (cfg_i),
    .out_o         (out_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  // A new address never overwrites a word still waiting at the output.
  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_o.valid || out_o.ready))
    else $error("address emitted over a pending output word");

  // After an input word is taken, the next one waits for its decode.
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while a decode is in progress");

  // Once a word is taken with nothing new behind it, output goes idle.
  a_last_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !cmd.emit) |=> !out_o.valid)
    else $error("output still valid after its word was taken");

endmodule

[tb/tb_relr_relocation_decoder.sv]
`timescale 1ns / 100ps
// Self-checking testbench for relr_relocation_decoder: a directed table of RELR
// words and load-bias writes, then random tables, checked against a predictor.
// Depends on relr_pkg and the channel interfaces in relr_if.sv.
module tb_relr_relocation_decoder;

  typedef enum logic [1:0] {
    ROW_CFG,   // write the load bias
    ROW_NONE,  // word that yields no address
    ROW_ONE,   // word with one address typed in
    ROW_PRED   // word checked against the predictor
  } row_kind_e;

  typedef struct {
    row_kind_e                  kind;
    bit                         st;
    logic [relr_pkg::AddrW-1:0] val;
    logic [relr_pkg::AddrW-1:0] addr;
  } row_t;

  typedef struct {
    logic [relr_pkg::AddrW-1:0] addr;
    logic                       last;
  } reloc_t;

  localparam int NumRows     = 23;
  localparam int DrainCycles = 100;
  localparam int WordsPerBlk = 34;

  logic clk_i = 1'b0;
  logic rst_ni;

  relr_in_if  in_ch ();
  relr_cfg_if cfg_ch ();
  relr_out_if out_ch ();

  relr_relocation_decoder uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .cfg_i (cfg_ch),
    .out_o (out_ch)
  );

  // Predictor state and the queue of addresses still owed by the block.
  logic [relr_pkg::AddrW-1:0] cursor_q;
  logic [relr_pkg::AddrW-1:0] bias_q;
  reloc_t                     relocs_due[$];

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned err_count;
  int unsigned words_sent;
  int unsigned relocs_checked;
  int unsigned bias_writes;

  row_t dir_rows[NumRows];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  // Expands one RELR word into the biased addresses it stands for. With keep
  // clear only the cursor moves, for rows whose result is typed in or empty.
  function automatic void expand_entry(input bit st,
                                       input logic [relr_pkg::AddrW-1:0] ent,
                                       input bit keep);
    reloc_t r;
    if (st) begin
      cursor_q = '0;
    end
    if (!ent[0]) begin
      if (keep && bias_q != '0) begin
        r.addr = ent + bias_q;
        r.last = 1'b1;
        relocs_due.push_back(r);
      end
      cursor_q = ent + relr_pkg::WordStep;
    end else begin
      for (int b = 1; b < relr_pkg::BitmapBits; b++) begin
        if (keep && bias_q != '0 && ent[b]) begin
          r.addr = cursor_q + relr_pkg::WordStep * relr_pkg::AddrW'(b - 1) + bias_q;
          r.last = ((ent >> (b + 1)) == '0);
          relocs_due.push_back(r);
        end
      end
      cursor_q = cursor_q + relr_pkg::BitmapStep;
    end
  endfunction

  function automatic logic [relr_pkg::AddrW-1:0] pick_address();
    logic [relr_pkg::AddrW-1:0] v;
    case ($urandom_range(3))
      0: v = {$urandom, $urandom};
      1: v = relr_pkg::AddrW'($urandom_range(4095)) << 3;
      2: v = '1 - relr_pkg::AddrW'($urandom_range(4095));
      default: v = {32'h0000_0000, $urandom};
    endcase
    v[0] = 1'b0;
    return v;
  endfunction

  function automatic logic [relr_pkg::AddrW-1:0] pick_entry();
    logic [relr_pkg::AddrW-1:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = pick_address();
      3, 4: begin
        v = 64'h1;
        repeat ($urandom_range(3, 1)) v[$urandom_range(63, 1)] = 1'b1;
      end
      5, 6: v = {$urandom, $urandom} | 64'h1;
      7: v = {$urandom, $urandom} | {$urandom, $urandom} | 64'h1;
      8: v = $urandom_range(1) ? '1 : 64'h1;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Offers one word and returns at the edge where it is taken. Valid stays
  // high into the next call unless that call idles first.
  task automatic push_word(input bit st, input logic [relr_pkg::AddrW-1:0] ent);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.table_start <= st;
    in_ch.relr_entry  <= ent;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // Waits until every owed address is out, then lets a word that yields no
  // address finish its walk before anything else happens.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (relocs_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_bias(input logic [relr_pkg::AddrW-1:0] b);
    cfg_ch.valid <= 1'b1;
    cfg_ch.bias  <= b;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    bias_q = b;
    bias_writes++;
  endtask

  always @(posedge clk_i) begin : mon
    reloc_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (relocs_due.size() == 0) begin
        note_error($sformatf("unexpected word: address %h last %b",
                             out_ch.patch_address, out_ch.last));
      end else begin
        want = relocs_due.pop_front();
        relocs_checked++;
        if (out_ch.patch_address !== want.addr || out_ch.last !== want.last) begin
          note_error($sformatf("address %h last %b, expected address %h last %b",
                               out_ch.patch_address, out_ch.last, want.addr, want.last));
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    #5_000_000;
    $display("tb_relr_relocation_decoder: done, errors");
    $finish;
  end

  initial begin
    bit                         st;
    logic [relr_pkg::AddrW-1:0] ent;
    logic [relr_pkg::AddrW-1:0] bias;
    int                         n_left;
    int                         tbl_len;

    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.table_start = 1'b0;
    in_ch.relr_entry  = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.bias       = '0;
    out_ch.ready      = 1'b0;
    cursor_q          = '0;
    bias_q            = '0;
    err_count         = 0;
    words_sent        = 0;
    relocs_checked    = 0;
    bias_writes       = 0;
    src_idle_pct      = 14;
    sink_stall_pct    = 74;

    dir_rows = '{
      // Bias is zero out of reset, so nothing comes out.
      '{ROW_NONE, 1'b1, 64'h0000_0000_0000_1000, 64'h0},
      '{ROW_NONE, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
      '{ROW_CFG,  1'b0, 64'h0000_0000_0000_0001, 64'h0},
      '{ROW_ONE,  1'b1, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001},
      '{ROW_ONE,  1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF},
      // The cursor has wrapped past the top here.
      '{ROW_PRED, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
      '{ROW_NONE, 1'b0, 64'h0000_0000_0000_0001, 64'h0},
      '{ROW_PRED, 1'b0, 64'h8000_0000_0000_0001, 64'h0},
      '{ROW_PRED, 1'b1, 64'h0000_0000_0000_0003, 64'h0},
      '{ROW_CFG,  1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
      '{ROW_ONE,  1'b1, 64'h0000_0000_0000_0010, 64'h0000_0000_0000_000F},
      '{ROW_PRED, 1'b0, 64'hAAAA_AAAA_AAAA_AAAB, 64'h0},
      '{ROW_PRED, 1'b0, 64'h5555_5555_5555_5555, 64'h0},
      '{ROW_CFG,  1'b0, 64'h8000_0000_0000_0000, 64'h0},
      '{ROW_ONE,  1'b0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000},
      '{ROW_PRED, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
      // A zero bias silences the output but the cursor keeps moving.
      '{ROW_CFG,  1'b0, 64'h0000_0000_0000_0000, 64'h0},
      '{ROW_NONE, 1'b0, 64'h0000_0000_0000_2000, 64'h0},
      '{ROW_NONE, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
      '{ROW_CFG,  1'b0, 64'h0000_0000_0000_1000, 64'h0},
      '{ROW_PRED, 1'b0, 64'h0000_0000_0000_0005, 64'h0},
      '{ROW_ONE,  1'b1, 64'h7FFF_FFFF_FFFF_FFF8, 64'h8000_0000_0000_0FF8},
      '{ROW_PRED, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_bias(dir_rows[i].val);
      end else begin
        push_word(dir_rows[i].st, dir_rows[i].val);
        expand_entry(dir_rows[i].st, dir_rows[i].val, dir_rows[i].kind == ROW_PRED);
        if (dir_rows[i].kind == ROW_ONE) begin
          relocs_due.push_back('{addr: dir_rows[i].addr, last: 1'b1});
        end
      end
    end

    // Random tables: mostly a start-flagged address word followed by a run of
    // bitmaps and addresses, with a few stray start flags mixed in.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 14;
          sink_stall_pct = 74;
        end
        1: begin
          src_idle_pct   = 74;
          sink_stall_pct = 14;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        case ($urandom_range(7))
          0: bias = '0;
          1: bias = 64'h1;
          2: bias = '1;
          3: bias = 64'h8000_0000_0000_0000;
          default: bias = {$urandom, $urandom};
        endcase
        drain();
        write_bias(bias);
        n_left = WordsPerBlk;
        while (n_left > 0) begin
          tbl_len = $urandom_range(8, 1);
          for (int k = 0; k < tbl_len && n_left > 0; k++) begin
            if (k == 0) begin
              st  = ($urandom_range(9) != 0);
              ent = ($urandom_range(4) != 0) ? pick_address() : pick_entry();
            end else begin
              st  = ($urandom_range(19) == 0);
              ent = pick_entry();
            end
            push_word(st, ent);
            expand_entry(st, ent, 1'b1);
            n_left--;
          end
        end
      end
    end

    drain();
    $display("Sent %0d RELR words under %0d load-bias settings, checked %0d addresses.",
             words_sent, bias_writes, relocs_checked);
    $display("Mismatches: %0d.", err_count);
    if (err_count == 0) begin
      $display("tb_relr_relocation_decoder: done, clean");
    end else begin
      $display("tb_relr_relocation_decoder: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/relr_pkg.sv
rtl/core/relr_if.sv
rtl/core/relr_ctrl.sv
rtl/core/relr_dp.sv
rtl/core/relr_relocation_decoder.sv
tb/tb_relr_relocation_decoder.sv
